// ----- rtl/dpps_pkg.sv -----
// dpps_pkg: shared widths, reset values, register indexes and sequencer states
// for the dash pattern point segmenter
// depends on nothing
package dpps_pkg;

	localparam int MAX_RUN_DEF = 64;

	localparam int COORD_W = 24;
	localparam int TIME_W  = 32;
	localparam int WIDTH_W = 16;
	localparam int LEN_W   = 23;
	localparam int ID_W    = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int DIST_W  = DIFF_W;
	localparam int REM_W   = DIST_W + 1;
	localparam int ALU_W   = REM_W + 2;
	localparam int ROOT_STEPS = SQ_W / 2;
	localparam int CNT_W   = $clog2(ROOT_STEPS);
	localparam int CFG_IDX_W = 1;

	localparam logic [LEN_W-1:0] DASH_LEN_RST = LEN_W'(2560);
	localparam logic [LEN_W-1:0] GAP_LEN_RST  = LEN_W'(1280);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DASH_LENGTH = 1'b0,
		CFG_GAP_LENGTH  = 1'b1
	} cfg_reg_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FIRST = 8'b0000_0010,
		S_SQX   = 8'b0000_0100,
		S_SQY   = 8'b0000_1000,
		S_ROOT  = 8'b0001_0000,
		S_DIST  = 8'b0010_0000,
		S_SPACE = 8'b0100_0000,
		S_STEP  = 8'b1000_0000
	} seq_state_t;

endpackage

// ----- rtl/dash_pattern_point_segmenter_unit.sv -----
// dash_pattern_point_segmenter_unit: top level, splits a trail into dashes and gaps
// by travelled distance using one shared subtractor under a small sequencer
// depends on dpps_pkg
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-----------------------------------------
// in      | request   | in_valid/in_stall  | pos_x pos_y time_stamp width new_stroke
// out     | result    | out_valid/out_stall| out_x out_y out_time out_width segment_id
//         |           |                    | last truncated
// cfg     | write     | cfg_wr_en          | cfg_index cfg_data
//
// first point of a stroke: its result is loaded in S_FIRST, which waits while the result stalls
// other points: two squares on one multiplier, 25 root digits and a zero check give the distance,
// then S_SPACE and S_STEP for each dash or gap step, the last included,
// at most MAX_RUN results; every step goes through the one shared subtractor
// in_stall is high from acceptance until the last step; a stalled result holds the sequencer
// reset is asynchronous and needs no clearing pass
module dash_pattern_point_segmenter_unit #(
	parameter int MAX_RUN = dpps_pkg::MAX_RUN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [dpps_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [dpps_pkg::COORD_W-1:0]  pos_y,
	input  logic        [dpps_pkg::TIME_W-1:0]   time_stamp,
	input  logic        [dpps_pkg::WIDTH_W-1:0]  width,
	input  logic                                 new_stroke,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [dpps_pkg::COORD_W-1:0]  out_x,
	output logic signed [dpps_pkg::COORD_W-1:0]  out_y,
	output logic        [dpps_pkg::TIME_W-1:0]   out_time,
	output logic        [dpps_pkg::WIDTH_W-1:0]  out_width,
	output logic        [dpps_pkg::ID_W-1:0]     segment_id,
	output logic                                 last,
	output logic                                 truncated,
	input  logic                                 cfg_wr_en,
	input  logic        [dpps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [dpps_pkg::LEN_W-1:0]    cfg_data
);

	localparam int N_W = $clog2(MAX_RUN);
	localparam int ROOT_STEPS = dpps_pkg::ROOT_STEPS;

	dpps_pkg::seq_state_t state_q, state_d;

	logic signed [dpps_pkg::COORD_W-1:0] x_q, y_q, prev_x_q, prev_y_q;
	logic        [dpps_pkg::TIME_W-1:0]  time_q;
	logic        [dpps_pkg::WIDTH_W-1:0] width_q;
	logic signed [dpps_pkg::DIFF_W-1:0]  dx_q, dy_q, mul_op;
	logic signed [dpps_pkg::SQ_W-1:0]    prod;
	logic        [dpps_pkg::SQ_W-1:0]    sq_q;
	logic        [dpps_pkg::REM_W-1:0]   rem_q, rem_next;
	logic        [dpps_pkg::DIST_W-1:0]  root_q, root_next, dist_q, r;
	logic        [dpps_pkg::CNT_W-1:0]   cnt_q;
	logic        [dpps_pkg::LEN_W-1:0]   space_q, dash_len_q, gap_len_q, dash_prog_q, gap_prog_q;
	logic        [N_W-1:0]               n_q;
	logic        [dpps_pkg::ID_W-1:0]    counter_q, emit_id;
	logic                                have_prev_q, in_gap_q, out_valid_q;

	logic [dpps_pkg::ALU_W-1:0] alu_a, alu_b;
	logic [dpps_pkg::ALU_W:0]   alu_diff;
	logic                       alu_lt;

	logic accept, emit_ok, emit, emit_last, emit_trunc, cap, r_zero, r_short;

	assign in_stall = (state_q != dpps_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign emit_ok  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// shared multiplier for the two squares
	assign mul_op = (state_q == dpps_pkg::S_SQX) ? dx_q : dy_q;
	assign prod   = mul_op * mul_op;

	// shared subtractor: root digits, space left, distance against space
	always_comb begin
		unique case (state_q)
			dpps_pkg::S_ROOT: begin
				alu_a = {rem_q, sq_q[dpps_pkg::SQ_W-1 -: 2]};
				alu_b = {1'b0, root_q, 2'b01};
			end
			dpps_pkg::S_SPACE: begin
				alu_a = dpps_pkg::ALU_W'(in_gap_q ? gap_len_q : dash_len_q);
				alu_b = dpps_pkg::ALU_W'(in_gap_q ? gap_prog_q : dash_prog_q);
			end
			default: begin
				alu_a = dpps_pkg::ALU_W'(dist_q);
				alu_b = dpps_pkg::ALU_W'(space_q);
			end
		endcase
	end

	assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
	assign alu_lt   = alu_diff[dpps_pkg::ALU_W];

	assign root_next = {root_q[dpps_pkg::DIST_W-2:0], !alu_lt};
	assign rem_next  = alu_lt ? alu_a[dpps_pkg::REM_W-1:0] : alu_diff[dpps_pkg::REM_W-1:0];

	assign r       = alu_diff[dpps_pkg::DIST_W-1:0];
	assign r_zero  = (r == '0);
	assign r_short = (r < {2'b00, gap_len_q});
	assign cap     = (n_q == N_W'(MAX_RUN - 1));

	// sequencer
	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		emit_id    = counter_q;
		emit_last  = 1'b0;
		emit_trunc = 1'b0;
		unique case (state_q)
			dpps_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (new_stroke || !have_prev_q) ? dpps_pkg::S_FIRST : dpps_pkg::S_SQX;
				end
			end
			dpps_pkg::S_FIRST: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = dpps_pkg::S_IDLE;
				end
			end
			dpps_pkg::S_SQX: state_d = dpps_pkg::S_SQY;
			dpps_pkg::S_SQY: state_d = dpps_pkg::S_ROOT;
			dpps_pkg::S_ROOT: begin
				if (cnt_q == dpps_pkg::CNT_W'(ROOT_STEPS - 1)) begin
					state_d = dpps_pkg::S_DIST;
				end
			end
			dpps_pkg::S_DIST: begin
				state_d = (dist_q == '0) ? dpps_pkg::S_IDLE : dpps_pkg::S_SPACE;
			end
			dpps_pkg::S_SPACE: state_d = dpps_pkg::S_STEP;
			dpps_pkg::S_STEP: begin
				if (emit_ok) begin
					if (in_gap_q) begin
						if (alu_lt) begin
							state_d = dpps_pkg::S_IDLE;
						end else begin
							emit       = 1'b1;
							emit_id    = counter_q + dpps_pkg::ID_W'(1);
							emit_last  = r_zero || cap;
							emit_trunc = cap && !r_zero;
							state_d    = emit_last ? dpps_pkg::S_IDLE : dpps_pkg::S_SPACE;
						end
					end else begin
						emit = 1'b1;
						if (alu_lt) begin
							emit_last = 1'b1;
							state_d   = dpps_pkg::S_IDLE;
						end else begin
							// a short remainder ends inside the following gap
							emit_last  = r_zero || cap || r_short;
							emit_trunc = cap && !r_zero;
							state_d    = emit_last ? dpps_pkg::S_IDLE : dpps_pkg::S_SPACE;
						end
					end
				end
			end
			default: state_d = dpps_pkg::S_IDLE;
		endcase
	end

	// control and dash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dpps_pkg::S_IDLE;
			dash_len_q  <= dpps_pkg::DASH_LEN_RST;
			gap_len_q   <= dpps_pkg::GAP_LEN_RST;
			counter_q   <= '0;
			dash_prog_q <= '0;
			gap_prog_q  <= '0;
			in_gap_q    <= 1'b0;
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				unique case (dpps_pkg::cfg_reg_t'(cfg_index))
					dpps_pkg::CFG_DASH_LENGTH: dash_len_q <= cfg_data;
					dpps_pkg::CFG_GAP_LENGTH:  gap_len_q  <= cfg_data;
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				dpps_pkg::S_IDLE: begin
					if (accept) begin
						if (new_stroke) begin
							counter_q   <= counter_q + dpps_pkg::ID_W'(1);
							dash_prog_q <= '0;
							gap_prog_q  <= '0;
							in_gap_q    <= 1'b0;
						end
						if (new_stroke || !have_prev_q) begin
							have_prev_q <= 1'b1;
						end
					end
				end
				dpps_pkg::S_SQY:  cnt_q <= '0;
				dpps_pkg::S_ROOT: cnt_q <= cnt_q + dpps_pkg::CNT_W'(1);
				dpps_pkg::S_DIST: n_q <= '0;
				dpps_pkg::S_STEP: begin
					if (emit_ok) begin
						if (in_gap_q) begin
							if (alu_lt) begin
								gap_prog_q <= gap_prog_q + dist_q[dpps_pkg::LEN_W-1:0];
							end else begin
								in_gap_q    <= 1'b0;
								gap_prog_q  <= '0;
								dash_prog_q <= '0;
								counter_q   <= counter_q + dpps_pkg::ID_W'(1);
								n_q         <= n_q + N_W'(1);
							end
						end else if (alu_lt) begin
							dash_prog_q <= dash_prog_q + dist_q[dpps_pkg::LEN_W-1:0];
						end else begin
							dash_prog_q <= '0;
							in_gap_q    <= 1'b1;
							gap_prog_q  <= (!cap && !r_zero && r_short) ?
								r[dpps_pkg::LEN_W-1:0] : '0;
							n_q         <= n_q + N_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			dpps_pkg::S_IDLE: begin
				if (accept) begin
					x_q     <= pos_x;
					y_q     <= pos_y;
					time_q  <= time_stamp;
					width_q <= width;
					dx_q    <= {pos_x[dpps_pkg::COORD_W-1], pos_x} -
					           {prev_x_q[dpps_pkg::COORD_W-1], prev_x_q};
					dy_q    <= {pos_y[dpps_pkg::COORD_W-1], pos_y} -
					           {prev_y_q[dpps_pkg::COORD_W-1], prev_y_q};
				end
			end
			dpps_pkg::S_FIRST: begin
				if (emit_ok) begin
					prev_x_q <= x_q;
					prev_y_q <= y_q;
				end
			end
			dpps_pkg::S_SQX: sq_q <= unsigned'(prod);
			dpps_pkg::S_SQY: begin
				sq_q   <= sq_q + unsigned'(prod);
				rem_q  <= '0;
				root_q <= '0;
			end
			dpps_pkg::S_ROOT: begin
				rem_q  <= rem_next;
				root_q <= root_next;
				sq_q   <= {sq_q[dpps_pkg::SQ_W-3:0], 2'b00};
				if (cnt_q == dpps_pkg::CNT_W'(ROOT_STEPS - 1)) begin
					dist_q <= root_next;
				end
			end
			dpps_pkg::S_DIST: begin
				if (dist_q != '0) begin
					prev_x_q <= x_q;
					prev_y_q <= y_q;
				end
			end
			dpps_pkg::S_SPACE: begin
				space_q <= alu_lt ? '0 : alu_diff[dpps_pkg::LEN_W-1:0];
			end
			dpps_pkg::S_STEP: begin
				if (emit_ok && !alu_lt) begin
					dist_q <= r;
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			out_x      <= x_q;
			out_y      <= y_q;
			out_time   <= time_q;
			out_width  <= width_q;
			segment_id <= emit_id;
			last       <= emit_last;
			truncated  <= emit_trunc;
		end
	end

	a_trunc_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!truncated || last))
		else $error("truncated result without last");

	a_step_has_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dpps_pkg::S_STEP) |-> (dist_q != '0) && have_prev_q)
		else $error("dash step with no distance left");

	a_stroke_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && new_stroke) |=> (counter_q == $past(counter_q) + dpps_pkg::ID_W'(1)))
		else $error("new stroke did not advance the segment id");

	a_root_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dpps_pkg::S_SQY) |=> (state_q == dpps_pkg::S_ROOT)
			##(ROOT_STEPS) (state_q == dpps_pkg::S_DIST))
		else $error("square root did not take its fixed digit count");

endmodule

// ----- test/dash_pattern_point_segmenter_checker.sv -----
`timescale 1ns / 100ps
// dash_pattern_point_segmenter_checker: watches the request, result and register
// channels, predicts every emitted point and compares it field by field
// depends on dpps_pkg
module dash_pattern_point_segmenter_checker #(
	parameter int MAX_RUN = dpps_pkg::MAX_RUN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic signed [dpps_pkg::COORD_W-1:0]   pos_x,
	input  logic signed [dpps_pkg::COORD_W-1:0]   pos_y,
	input  logic        [dpps_pkg::TIME_W-1:0]    time_stamp,
	input  logic        [dpps_pkg::WIDTH_W-1:0]   width,
	input  logic                                  new_stroke,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [dpps_pkg::COORD_W-1:0]   out_x,
	input  logic signed [dpps_pkg::COORD_W-1:0]   out_y,
	input  logic        [dpps_pkg::TIME_W-1:0]    out_time,
	input  logic        [dpps_pkg::WIDTH_W-1:0]   out_width,
	input  logic        [dpps_pkg::ID_W-1:0]      segment_id,
	input  logic                                  last,
	input  logic                                  truncated,
	input  logic                                  cfg_wr_en,
	input  logic        [dpps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [dpps_pkg::LEN_W-1:0]     cfg_data,
	output int                                    errors,
	output int                                    pending,
	output int                                    seen,
	output int                                    clipped
);

	typedef struct packed {
		logic signed [dpps_pkg::COORD_W-1:0] x;
		logic signed [dpps_pkg::COORD_W-1:0] y;
		logic [dpps_pkg::TIME_W-1:0]         t;
		logic [dpps_pkg::WIDTH_W-1:0]        w;
		logic [dpps_pkg::ID_W-1:0]           seg;
		logic                                fin;
		logic                                cut;
	} dash_point_t;

	dash_point_t due_points[$];
	dash_point_t held_pt;
	dash_point_t want_pt;
	bit held_ok;

	logic [dpps_pkg::LEN_W-1:0] dash_len;
	logic [dpps_pkg::LEN_W-1:0] gap_len;
	logic [dpps_pkg::ID_W-1:0] dash_id;
	logic [dpps_pkg::COORD_W-1:0] dash_prog;
	logic [dpps_pkg::COORD_W-1:0] gap_prog;
	logic gap_phase;
	logic signed [dpps_pkg::COORD_W-1:0] prev_x;
	logic signed [dpps_pkg::COORD_W-1:0] prev_y;
	logic have_prev;

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int i = 25; i >= 0; i--) begin
			trial = r | (64'd1 << i);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	// the newest point is held back so the final one can get its flags
	function automatic void stage_point(input logic [dpps_pkg::ID_W-1:0] id);
		if (held_ok)
			due_points.push_back(held_pt);
		held_pt = '{x: pos_x, y: pos_y, t: time_stamp, w: width, seg: id, fin: 1'b0,
			cut: 1'b0};
		held_ok = 1'b1;
	endfunction

	function automatic void segment_point();
		longint dx;
		longint dy;
		longint unsigned travel;
		longint unsigned space;
		int n;
		bit cut;
		held_ok = 1'b0;
		n = 0;
		cut = 1'b0;
		if (new_stroke) begin
			dash_id = dash_id + dpps_pkg::ID_W'(1);
			dash_prog = '0;
			gap_prog = '0;
			gap_phase = 1'b0;
			have_prev = 1'b0;
		end
		if (!have_prev) begin
			prev_x = pos_x;
			prev_y = pos_y;
			have_prev = 1'b1;
			stage_point(dash_id);
		end else begin
			dx = longint'(pos_x) - longint'(prev_x);
			dy = longint'(pos_y) - longint'(prev_y);
			travel = floor_root(dx * dx + dy * dy);
			if (travel != 0) begin
				prev_x = pos_x;
				prev_y = pos_y;
			end
			while (travel != 0 && !cut) begin
				if (n >= MAX_RUN) begin
					cut = 1'b1;
				end else if (gap_phase) begin
					space = (gap_prog < gap_len) ? 64'(gap_len - gap_prog) : 64'd0;
					if (travel < space) begin
						gap_prog = gap_prog + dpps_pkg::COORD_W'(travel);
						travel = 0;
					end else begin
						travel = travel - space;
						gap_phase = 1'b0;
						gap_prog = '0;
						dash_prog = '0;
						dash_id = dash_id + dpps_pkg::ID_W'(1);
						stage_point(dash_id);
						n++;
					end
				end else begin
					space = (dash_prog < dash_len) ? 64'(dash_len - dash_prog) : 64'd0;
					if (travel < space) begin
						dash_prog = dash_prog + dpps_pkg::COORD_W'(travel);
						travel = 0;
					end else begin
						travel = travel - space;
						dash_prog = '0;
						gap_phase = 1'b1;
						gap_prog = '0;
					end
					stage_point(dash_id);
					n++;
				end
			end
		end
		if (held_ok) begin
			held_pt.fin = 1'b1;
			held_pt.cut = cut;
			due_points.push_back(held_pt);
		end
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("mismatch on %s of result %0d: expected %0h, got %0h", name, seen,
					want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_len = dpps_pkg::DASH_LEN_RST;
			gap_len = dpps_pkg::GAP_LEN_RST;
			dash_id = '0;
			dash_prog = '0;
			gap_prog = '0;
			gap_phase = 1'b0;
			prev_x = '0;
			prev_y = '0;
			have_prev = 1'b0;
			held_ok = 1'b0;
			due_points.delete();
			errors = 0;
			seen = 0;
			clipped = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen++;
				if (due_points.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result %0d arrived with nothing expected", seen);
				end else begin
					want_pt = due_points.pop_front();
					check_field("out_x", 64'(want_pt.x), 64'(out_x));
					check_field("out_y", 64'(want_pt.y), 64'(out_y));
					check_field("out_time", 64'(want_pt.t), 64'(out_time));
					check_field("out_width", 64'(want_pt.w), 64'(out_width));
					check_field("segment_id", 64'(want_pt.seg), 64'(segment_id));
					check_field("last", 64'(want_pt.fin), 64'(last));
					check_field("truncated", 64'(want_pt.cut), 64'(truncated));
					if (want_pt.cut)
						clipped++;
				end
			end
			if (cfg_wr_en) begin
				if (cfg_index == dpps_pkg::CFG_DASH_LENGTH)
					dash_len = cfg_data;
				else if (cfg_index == dpps_pkg::CFG_GAP_LENGTH)
					gap_len = cfg_data;
			end
			if (in_valid && !in_stall)
				segment_point();
			pending <= due_points.size();
		end
	end

endmodule

// ----- test/dash_pattern_point_segmenter_unit_tb.sv -----
`timescale 1ns / 100ps
// dash_pattern_point_segmenter_unit_tb: drives trail point requests and length settings
// into the segmenter, with random idling on both channels, and gives the verdict
// depends on dpps_pkg, dash_pattern_point_segmenter_unit, dash_pattern_point_segmenter_checker
module dash_pattern_point_segmenter_unit_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int POS_MIN = -8388608;
	localparam int POS_MAX = 8388607;
	localparam logic [dpps_pkg::LEN_W-1:0] LEN_MAX = dpps_pkg::LEN_W'(8388607);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [dpps_pkg::COORD_W-1:0] pos_x = '0;
	logic signed [dpps_pkg::COORD_W-1:0] pos_y = '0;
	logic [dpps_pkg::TIME_W-1:0] time_stamp = '0;
	logic [dpps_pkg::WIDTH_W-1:0] width = '0;
	logic new_stroke = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [dpps_pkg::COORD_W-1:0] out_x;
	logic signed [dpps_pkg::COORD_W-1:0] out_y;
	logic [dpps_pkg::TIME_W-1:0] out_time;
	logic [dpps_pkg::WIDTH_W-1:0] out_width;
	logic [dpps_pkg::ID_W-1:0] segment_id;
	logic last;
	logic truncated;
	logic cfg_wr_en = 1'b0;
	dpps_pkg::cfg_reg_t cfg_index = dpps_pkg::CFG_DASH_LENGTH;
	logic [dpps_pkg::LEN_W-1:0] cfg_data = '0;

	int errors;
	int pending;
	int seen;
	int clipped;
	int cycles = 0;
	int hold_cnt = 0;
	int cur_x = 0;
	int cur_y = 0;
	int sent = 0;
	int settings = 0;
	bit quiet = 1'b0;

	always #6 clk = ~clk;

	dash_pattern_point_segmenter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .time_stamp(time_stamp), .width(width),
		.new_stroke(new_stroke),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_time(out_time), .out_width(out_width),
		.segment_id(segment_id), .last(last), .truncated(truncated),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	dash_pattern_point_segmenter_checker dash_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .time_stamp(time_stamp), .width(width),
		.new_stroke(new_stroke),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_time(out_time), .out_width(out_width),
		.segment_id(segment_id), .last(last), .truncated(truncated),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .seen(seen), .clipped(clipped)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side stall bursts, with long free stretches now and then
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (!out_stall && $urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			hold_cnt <= int'($urandom_range(0, 11));
		end else begin
			out_stall <= 1'b0;
			hold_cnt <= ($urandom_range(0, 7) == 0) ? int'($urandom_range(40, 150))
				: int'($urandom_range(0, 20));
		end
	end

	function automatic int clamp24(input longint v);
		if (v > POS_MAX)
			return POS_MAX;
		if (v < POS_MIN)
			return POS_MIN;
		return int'(v);
	endfunction

	function automatic int jitter(input int reach);
		int m;
		m = int'($urandom_range(0, reach));
		return ($urandom_range(0, 1) != 0) ? m : -m;
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, 24'hFF_FFFF)) + POS_MIN;
	endfunction

	task automatic send_point(input int x, input int y, input bit ns, input bit counts,
		input logic [dpps_pkg::TIME_W-1:0] t, input logic [dpps_pkg::WIDTH_W-1:0] w);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		pos_x <= dpps_pkg::COORD_W'(x);
		pos_y <= dpps_pkg::COORD_W'(y);
		time_stamp <= t;
		width <= w;
		new_stroke <= ns;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && !in_stall));
		cur_x = x;
		cur_y = y;
		if (counts)
			sent++;
	endtask

	task automatic walk(input int reach, input bit ns);
		int x;
		int y;
		x = clamp24(longint'(cur_x) + jitter(reach));
		y = clamp24(longint'(cur_y) + jitter(reach));
		send_point(x, y, ns, 1'b1, $urandom, dpps_pkg::WIDTH_W'($urandom_range(0, 65535)));
	endtask

	// every expected result in, then room for a request that emits nothing
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (48) @(posedge clk);
	endtask

	task automatic set_lengths(input logic [dpps_pkg::LEN_W-1:0] dl,
		input logic [dpps_pkg::LEN_W-1:0] gl);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= dpps_pkg::CFG_DASH_LENGTH;
		cfg_data <= dl;
		@(posedge clk);
		cfg_index <= dpps_pkg::CFG_GAP_LENGTH;
		cfg_data <= gl;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	task automatic run_phase(input logic [dpps_pkg::LEN_W-1:0] dl,
		input logic [dpps_pkg::LEN_W-1:0] gl, input int items);
		int reach;
		int far;
		int n;
		int len;
		int pick;
		bit first;
		set_lengths(dl, gl);
		reach = (int'(dl) + int'(gl)) * 2;
		if (reach > 3_000_000)
			reach = 3_000_000;
		if (reach < 2)
			reach = 2;
		far = reach * 30;
		if (far > 8_000_000)
			far = 8_000_000;
		n = 0;
		first = 1'b1;
		while (n < items) begin
			pick = int'($urandom_range(0, 9));
			if (pick == 0) begin
				send_point(any_coord(), any_coord(), 1'($urandom_range(0, 1)), 1'b1, $urandom,
					dpps_pkg::WIDTH_W'($urandom_range(0, 65535)));
				n++;
			end else if (pick == 1) begin
				// same point again: no distance, nothing emitted
				send_point(cur_x, cur_y, 1'b0, 1'b0, $urandom,
					dpps_pkg::WIDTH_W'($urandom_range(0, 65535)));
			end else begin
				// the first stroke after a length change carries its progress over
				len = int'($urandom_range(2, 8));
				walk(reach, !first && $urandom_range(0, 3) != 0);
				for (int k = 0; k < len; k++)
					walk(($urandom_range(0, 7) == 0) ? far : reach, 1'b0);
				n += len + 1;
			end
			first = 1'b0;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset lengths: first point, no move, inside a dash, dash and gap edges
		send_point(0, 0, 1'b0, 1'b1, 32'h0, 16'h0);
		send_point(0, 0, 1'b0, 1'b0, 32'h1, 16'h1);
		send_point(1000, 0, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
		send_point(3560, 0, 1'b0, 1'b1, 32'h5555_5555, 16'hAAAA);
		send_point(3840, 0, 1'b0, 1'b1, 32'hAAAA_AAAA, 16'h5555);
		send_point(5376, 2048, 1'b0, 1'b1, $urandom, 16'h1234);
		// coordinate extremes, long runs that hit the cap
		send_point(POS_MAX, POS_MAX, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
		send_point(POS_MIN, POS_MIN, 1'b0, 1'b1, 32'h0, 16'h0);
		send_point(POS_MIN, POS_MIN, 1'b1, 1'b1, $urandom, 16'h00FF);
		send_point(POS_MIN + 1, POS_MIN, 1'b0, 1'b1, $urandom, 16'hFF00);
		send_point(POS_MAX, POS_MIN, 1'b0, 1'b1, $urandom, 16'h8000);
		send_point(POS_MAX, POS_MAX, 1'b0, 1'b1, $urandom, 16'h0001);
		// zero lengths: every boundary is taken at once
		set_lengths('0, '0);
		send_point(POS_MAX - 7, POS_MAX - 7, 1'b0, 1'b1, $urandom, 16'h7FFF);
		send_point(0, 0, 1'b1, 1'b1, $urandom, 16'h0F0F);
		send_point(1, 1, 1'b0, 1'b1, $urandom, 16'hF0F0);

		run_phase(dpps_pkg::LEN_W'(1), dpps_pkg::LEN_W'(1), 22);
		run_phase(LEN_MAX, LEN_MAX, 22);
		run_phase(dpps_pkg::LEN_W'(1), LEN_MAX, 22);
		run_phase(LEN_MAX, dpps_pkg::LEN_W'(1), 22);
		run_phase(dpps_pkg::LEN_W'($urandom_range(1, 20000)),
			dpps_pkg::LEN_W'($urandom_range(1, 20000)), 22);
		run_phase(dpps_pkg::LEN_W'($urandom_range(1, 20000)),
			dpps_pkg::LEN_W'($urandom_range(1, 20000)), 22);
		quiet = 1'b1;
		run_phase(dpps_pkg::DASH_LEN_RST, dpps_pkg::GAP_LEN_RST, 16);
		settle();

		$display("%0d trail points sent under %0d length settings, zero and both extremes in",
			sent, settings);
		$display("%0d emitted points checked, %0d of them cut short at the run cap",
			seen, clipped);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
